### hdl/u2w_pkg.sv
// ----------------------------------------------------------------------------
// u2w_pkg
// Shared types, constants and decode functions of the UTF-8 to WinAnsi
// escaper: lead byte classes, the code point to WinAnsi table and the job
// record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package u2w_pkg;

  // job queue depth and pointer width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // output characters with a special role
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // sequence lengths given by a lead byte
  localparam logic [2:0] LEN_STRAY = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // one complete or truncated byte sequence, bytes[0] first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            fin;
  } job_t;

  // sequence length from a lead byte, LEN_STRAY for a stray byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] l;
    if (b[7] == 1'b0) begin
      l = LEN_ONE;
    end else if ((b & 8'hE0) == 8'hC0) begin
      l = LEN_TWO;
    end else if ((b & 8'hF0) == 8'hE0) begin
      l = LEN_THREE;
    end else if ((b & 8'hF8) == 8'hF0) begin
      l = LEN_FOUR;
    end else begin
      l = LEN_STRAY;
    end
    return l;
  endfunction

  // code point to WinAnsi byte, '?' where there is no mapping
  function automatic logic [7:0] map_code_point(input logic [15:0] cp);
    logic [7:0] wa;
    if (cp == 16'h0000) begin
      wa = CH_QMARK;
    end else if (cp <= 16'h007F) begin
      wa = cp[7:0];
    end else if (cp inside {[16'h00A0:16'h00FF]}) begin
      wa = cp[7:0];
    end else begin
      case (cp)
        16'h20AC: wa = 8'h80;
        16'h201A: wa = 8'h82;
        16'h0192: wa = 8'h83;
        16'h201E: wa = 8'h84;
        16'h2026: wa = 8'h85;
        16'h2020: wa = 8'h86;
        16'h2021: wa = 8'h87;
        16'h02C6: wa = 8'h88;
        16'h2030: wa = 8'h89;
        16'h0160: wa = 8'h8A;
        16'h2039: wa = 8'h8B;
        16'h0152: wa = 8'h8C;
        16'h017D: wa = 8'h8E;
        16'h2018: wa = 8'h91;
        16'h2019: wa = 8'h92;
        16'h201C: wa = 8'h93;
        16'h201D: wa = 8'h94;
        16'h2022: wa = 8'h95;
        16'h2013: wa = 8'h96;
        16'h2014: wa = 8'h97;
        16'h02DC: wa = 8'h98;
        16'h2122: wa = 8'h99;
        16'h0161: wa = 8'h9A;
        16'h203A: wa = 8'h9B;
        16'h0153: wa = 8'h9C;
        16'h017E: wa = 8'h9E;
        16'h0178: wa = 8'h9F;
        default:  wa = CH_QMARK;
      endcase
    end
    return wa;
  endfunction

endpackage

### hdl/u2w_front.sv
// ----------------------------------------------------------------------------
// u2w_front
// Front end: collects the bytes of a multi-byte sequence and hands each
// complete or truncated sequence to the job queue as one job.
// ----------------------------------------------------------------------------
module u2w_front import u2w_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_accept,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       push,
  output job_t       push_job
);

  logic [7:0] held [3];
  logic [1:0] held_count;
  logic [2:0] seq_len;

  logic [2:0] lead_len;
  logic [2:0] total;
  logic       hold;

  // classify the incoming byte
  always_comb begin
    lead_len = lead_length(in_byte);
    total    = {1'b0, held_count} + 3'd1;
    if (held_count == 2'd0) begin
      hold = (lead_len >= LEN_TWO) && !in_final;
    end else begin
      hold = (total < seq_len) && !in_final;
    end
  end

  // job assembly: held bytes first, then the new byte
  always_comb begin
    push_job.bytes[0] = (held_count == 2'd0) ? in_byte : held[0];
    push_job.bytes[1] = (held_count > 2'd1) ? held[1] : in_byte;
    push_job.bytes[2] = (held_count > 2'd2) ? held[2] : in_byte;
    push_job.bytes[3] = in_byte;
    push_job.len      = total;
    push_job.fin      = in_final;
  end

  assign push = in_accept && !hold;

  // sequence tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len    <= LEN_ONE;
    end else if (in_accept) begin
      if (hold) begin
        held_count <= total[1:0];
        if (held_count == 2'd0) begin
          seq_len <= lead_len;
        end
      end else begin
        held_count <= 2'd0;
        seq_len    <= LEN_ONE;
      end
    end
  end

  // byte store of the pending sequence
  always_ff @(posedge clk) begin
    if (in_accept && hold) begin
      case (held_count)
        2'd0:    held[0] <= in_byte;
        2'd1:    held[1] <= in_byte;
        2'd2:    held[2] <= in_byte;
        default: held[2] <= held[2];
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a pending sequence is always shorter than its announced length
  a_pending_short: assert property (@(posedge clk) disable iff (rst)
    (held_count != 2'd0) |-> (seq_len >= LEN_TWO) && ({1'b0, held_count} < seq_len))
    else $error("pending sequence longer than its lead byte allows");
  // a job holds one to four bytes
  a_job_len: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_job.len >= LEN_ONE) && (push_job.len <= LEN_FOUR))
    else $error("job length out of range");
  // a job only leaves with an accepted item
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> in_accept)
    else $error("job pushed without an accepted item");
`endif

endmodule

### hdl/u2w_job_fifo.sv
// ----------------------------------------------------------------------------
// u2w_job_fifo
// Short queue of jobs between the front end and the back end, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module u2w_job_fifo import u2w_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic full,
  output logic empty
);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign head_job = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("job queue fill level out of range");
`endif

endmodule

### hdl/u2w_back.sv
// ----------------------------------------------------------------------------
// u2w_back
// Back end: walks a job's bytes, decodes each character, maps it to WinAnsi
// and, unless m_tready stalls, emits one byte per cycle, escape backslash first.
// ----------------------------------------------------------------------------
module u2w_back import u2w_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_ready,
  input  job_t       head_job,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  job_t       cur;
  logic       cur_valid;
  logic [2:0] pos;
  logic       esc_done;
  logic [2:0] n;

  logic [1:0]  idx1;
  logic [1:0]  idx2;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [2:0]  lead_len;
  logic        fits;
  logic [15:0] cp;
  logic [7:0]  wa;
  logic        esc;
  logic        char_done;
  logic [2:0]  next_pos;
  logic        last;
  logic        step;
  logic [7:0]  emit_byte;

  // character decode at the current position
  always_comb begin
    idx1     = pos[1:0] + 2'd1;
    idx2     = pos[1:0] + 2'd2;
    b0       = cur.bytes[pos[1:0]];
    b1       = cur.bytes[idx1];
    b2       = cur.bytes[idx2];
    lead_len = lead_length(b0);
    fits     = ({1'b0, pos} + {1'b0, lead_len}) <= {1'b0, cur.len};
    cp       = {8'h00, CH_QMARK};
    next_pos = pos + 3'd1;
    if (lead_len == LEN_ONE) begin
      cp = {8'h00, b0};
    end else if ((lead_len >= LEN_TWO) && fits) begin
      next_pos = pos + lead_len;
      if (lead_len == LEN_TWO) begin
        cp = {5'd0, b0[4:0], b1[5:0]};
      end else if (lead_len == LEN_THREE) begin
        cp = {b0[3:0], b1[5:0], b2[5:0]};
      end
    end
    wa        = map_code_point(cp);
    esc       = (wa == CH_LPAREN) || (wa == CH_RPAREN) || (wa == CH_BSLASH);
    char_done = !esc || esc_done;
    emit_byte = char_done ? wa : CH_BSLASH;
    last      = (char_done && (next_pos >= cur.len)) || (n == 3'd4);
  end

  // one output byte whenever the output register is free
  assign step = cur_valid && (!m_tvalid || m_tready);
  assign pop  = job_ready && (!cur_valid || (step && last));

  // job walk
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= 3'd0;
      esc_done  <= 1'b0;
      n         <= 3'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      pos       <= 3'd0;
      esc_done  <= 1'b0;
      n         <= 3'd0;
    end else if (step) begin
      if (last) begin
        cur_valid <= 1'b0;
      end else begin
        n <= n + 3'd1;
        if (char_done) begin
          pos      <= next_pos;
          esc_done <= 1'b0;
        end else begin
          esc_done <= 1'b1;
        end
      end
    end
  end

  // current job payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= emit_byte;
      m_tlast <= last;
      m_tuser <= last && cur.fin;
    end
  end

`ifndef ASSERT_OFF
  a_cap: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (n <= 3'd4))
    else $error("more than five bytes from one item");
  a_pos_in_job: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (pos < cur.len))
    else $error("decode position beyond the job");
  // the fifth byte of an item may be a lone backslash, otherwise its char follows
  a_escape_pair: assert property (@(posedge clk) disable iff (rst)
    (step && !char_done && !last) |=> (m_tdata == CH_BSLASH) && !m_tlast)
    else $error("escape backslash marked as last of its item");
`endif

endmodule

### hdl/utf8_to_winansi_escaper.sv
// The job of the input byte that completes a sequence is written to the job
// queue and, once the back end is idle, loaded as its current job before its
// first output byte is registered. Throughput: one output byte per cycle while
// m_tready allows, so one input byte per cycle for plain characters.
// Reset (rst, synchronous) empties the job queue and drops any pending
// sequence; held sequence bytes are not cleared.
// ----------------------------------------------------------------------------
// utf8_to_winansi_escaper
// UTF-8 to WinAnsi converter with backslash escaping of '(', ')' and
// backslash; a front end gathers sequences, a back end decodes and emits.
// ----------------------------------------------------------------------------
module utf8_to_winansi_escaper import u2w_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] text_end
);

  logic in_accept;
  logic push;
  job_t push_job;
  logic pop;
  job_t head_job;
  logic full;
  logic empty;

  // an item is taken whenever the job queue has room
  assign s_tready  = !full;
  assign in_accept = s_tvalid && s_tready;

  u2w_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .in_final  (s_tlast),
    .push      (push),
    .push_job  (push_job)
  );

  u2w_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  u2w_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (!empty),
    .head_job  (head_job),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
